[sv/sota_pkg.sv]
// ----------------------------------------------------------------------------
// sota_pkg
// Shared types and constants for the self-organizing array table.
// ----------------------------------------------------------------------------
`default_nettype none

package sota_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int TOTAL_W      = 36;
    localparam int LIMIT_W      = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    // operation codes carried in the kind field
    typedef enum logic [2:0] {
        K_APPEND   = 3'd0,
        K_INSERT   = 3'd1,
        K_DELETE   = 3'd2,
        K_GET      = 3'd3,
        K_SET      = 3'd4,
        K_SEARCH   = 3'd5,
        K_SRCH_TR  = 3'd6,
        K_SRCH_MTF = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_DEL,
        S_GET,
        S_SRCH,
        S_SWAP2,
        S_SCAN,
        S_DONE
    } state_t;

    // control from the sequencer to the statistics accumulator
    typedef struct packed {
        logic clear;
        logic acc;
        logic first;
    } stat_ctl_t;

endpackage

`default_nettype wire

[sv/self_organizing_array_table.sv]
// An item passes through an op phase (a single memory access, or a shift or
// search walking the memory), then a statistics scan over all live entries,
// then the output register. The table takes one item at a time; the next
// item is taken once the result is loaded into the output register. The
// single-port read of the entry memory sets the pace, one entry per cycle.
// Reset: count cleared, limit set to 16, entry memory left unwritten.
// ----------------------------------------------------------------------------
// self_organizing_array_table
// Packed list with append/insert/delete/get/set and three search modes,
// kept in a synchronous memory, reporting max/min/sum after every item.
// ----------------------------------------------------------------------------
`default_nettype none

module self_organizing_array_table #(
    parameter int CAPACITY = sota_pkg::CAPACITY_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [sota_pkg::LIMIT_W-1:0]        cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [2:0]                          kind,
    input  wire logic [3:0]                          position,
    input  wire logic signed [sota_pkg::DATA_W-1:0]  value,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [1:0]                               status,
    output logic signed [sota_pkg::DATA_W-1:0]       data,
    output logic [3:0]                               found_at,
    output logic [4:0]                               entry_count,
    output logic signed [sota_pkg::DATA_W-1:0]       largest,
    output logic signed [sota_pkg::DATA_W-1:0]       smallest,
    output logic signed [sota_pkg::TOTAL_W-1:0]      total
);
    import sota_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int IW    = (CW > 5) ? CW : 5;
    localparam int SUM0  = DATA_W + AW;
    localparam int SUM_W = (SUM0 > TOTAL_W) ? SUM0 : TOTAL_W;

    // entry memory
    logic signed [DATA_W-1:0] mem [CAPACITY];
    logic                     mem_we, mem_re;
    logic [AW-1:0]            mem_waddr, mem_raddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic signed [DATA_W-1:0] rd_data_reg;
    logic [AW-1:0]            rd_addr_reg;
    logic                     rvalid_reg;

    // sequencer state
    state_t                   state_reg, state_next;
    kind_t                    kind_reg, kind_next;
    logic [IW-1:0]            pos_reg, pos_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [LIMIT_W-1:0]       lim_reg;
    status_t                  status_reg, status_next;
    logic signed [DATA_W-1:0] data_reg, data_next;
    logic [IW-1:0]            found_reg, found_next;
    logic [IW-1:0]            idx_reg, idx_next;
    logic signed [DATA_W-1:0] first_reg, first_next;
    logic signed [DATA_W-1:0] prev_reg, prev_next;

    // output register
    logic                     out_valid_reg;
    logic                     out_load;
    status_t                  o_status_reg;
    logic signed [DATA_W-1:0] o_data_reg;
    logic [3:0]               o_found_reg;
    logic [4:0]               o_count_reg;
    logic signed [DATA_W-1:0] o_max_reg, o_min_reg;
    logic signed [TOTAL_W-1:0] o_total_reg;

    stat_ctl_t                st_ctl;
    logic signed [DATA_W-1:0] st_max, st_min;
    logic signed [SUM_W-1:0]  st_sum;

    logic [IW-1:0]            cnt_x, lim_x, eff_lim, rd_pos_x, idx_dec, found_dec;
    logic                     full, in_range, hit;

    assign cnt_x     = IW'(cnt_reg);
    assign lim_x     = IW'(lim_reg);
    assign eff_lim   = (lim_x > IW'(CAPACITY)) ? IW'(CAPACITY) : lim_x;
    assign full      = (cnt_x >= eff_lim);
    assign in_range  = (IW'(position) < cnt_x);
    assign rd_pos_x  = IW'(rd_addr_reg);
    assign idx_dec   = idx_reg - IW'(1);
    assign found_dec = found_reg - IW'(1);
    assign hit       = rvalid_reg && (rd_data_reg == val_reg);
    assign in_ready  = (state_reg == S_IDLE);

    // memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
            rd_addr_reg <= mem_raddr;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            lim_reg       <= LIMIT_RESET;
            rvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rvalid_reg <= mem_re;
            if (cfg_write)
                lim_reg <= cfg_data;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        data_reg   <= data_next;
        found_reg  <= found_next;
        idx_reg    <= idx_next;
        first_reg  <= first_next;
        prev_reg   <= prev_next;
        if (out_load)
        begin
            o_status_reg <= status_reg;
            o_data_reg   <= data_reg;
            o_found_reg  <= found_reg[3:0];
            o_count_reg  <= cnt_x[4:0];
            o_max_reg    <= st_max;
            o_min_reg    <= st_min;
            o_total_reg  <= st_sum[TOTAL_W-1:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        data_next   = data_reg;
        found_next  = found_reg;
        idx_next    = idx_reg;
        first_next  = first_reg;
        prev_next   = prev_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        st_ctl      = '0;
        out_load    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next   = kind_t'(kind);
                    pos_next    = IW'(position);
                    val_next    = value;
                    status_next = ST_OK;
                    data_next   = '0;
                    found_next  = '0;
                    idx_next    = '0;
                    state_next  = S_SCAN;
                    unique case (kind_t'(kind))
                        K_APPEND:
                        begin
                            if (full)
                                status_next = ST_FULL;
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = cnt_x[AW-1:0];
                                mem_wdata = value;
                                cnt_next  = cnt_reg + CW'(1);
                            end
                        end
                        K_INSERT:
                        begin
                            if (full)
                                status_next = ST_FULL;
                            else if (IW'(position) > cnt_x)
                                status_next = ST_RANGE;
                            else
                            begin
                                idx_next   = cnt_x;
                                state_next = S_INS;
                            end
                        end
                        K_DELETE:
                        begin
                            if (!in_range)
                                status_next = ST_RANGE;
                            else
                            begin
                                idx_next   = IW'(position);
                                state_next = S_DEL;
                            end
                        end
                        K_GET:
                        begin
                            if (!in_range)
                                status_next = ST_RANGE;
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(position);
                                state_next = S_GET;
                            end
                        end
                        K_SET:
                        begin
                            if (!in_range)
                                status_next = ST_RANGE;
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(position);
                                mem_wdata = value;
                            end
                        end
                        default:
                            state_next = S_SRCH;
                    endcase
                end
            end

            // shift up: read below, write one above, walking down to pos
            S_INS:
            begin
                if (rvalid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = rd_addr_reg + AW'(1);
                    mem_wdata = rd_data_reg;
                end
                if (idx_reg > pos_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_dec[AW-1:0];
                    idx_next  = idx_dec;
                end
                else if (!rvalid_reg)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = pos_reg[AW-1:0];
                    mem_wdata  = val_reg;
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = S_SCAN;
                end
            end

            // shift down: first read returns the removed entry
            S_DEL:
            begin
                if (rvalid_reg)
                begin
                    if (rd_pos_x == pos_reg)
                        data_next = rd_data_reg;
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = rd_addr_reg - AW'(1);
                        mem_wdata = rd_data_reg;
                    end
                end
                if (idx_reg < cnt_x)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg[AW-1:0];
                    idx_next  = idx_reg + IW'(1);
                end
                else if (!rvalid_reg)
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_SCAN;
                end
            end

            S_GET:
            begin
                if (rvalid_reg)
                begin
                    data_next  = rd_data_reg;
                    state_next = S_SCAN;
                end
            end

            // linear search; keeps the entry before the hit and entry 0
            S_SRCH:
            begin
                if (rvalid_reg)
                begin
                    prev_next = rd_data_reg;
                    if (rd_pos_x == '0)
                        first_next = rd_data_reg;
                end
                if (hit)
                begin
                    found_next = rd_pos_x;
                    state_next = S_SCAN;
                    case (kind_reg)
                        K_SRCH_TR:
                        begin
                            if (rd_pos_x != '0)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = rd_addr_reg;
                                mem_wdata  = prev_reg;
                                state_next = S_SWAP2;
                            end
                        end
                        K_SRCH_MTF:
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = rd_addr_reg;
                            mem_wdata  = (rd_pos_x == '0) ? rd_data_reg : first_reg;
                            state_next = S_SWAP2;
                        end
                        default:
                            state_next = S_SCAN;
                    endcase
                end
                else if (idx_reg < cnt_x)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg[AW-1:0];
                    idx_next  = idx_reg + IW'(1);
                end
                else if (!rvalid_reg)
                begin
                    status_next = ST_MISS;
                    state_next  = S_SCAN;
                end
            end

            // second half of a swap: key goes to its new place
            S_SWAP2:
            begin
                mem_we     = 1'b1;
                mem_waddr  = (kind_reg == K_SRCH_TR) ? found_dec[AW-1:0] : '0;
                mem_wdata  = val_reg;
                state_next = S_SCAN;
            end

            // stream all live entries through the accumulator
            S_SCAN:
            begin
                st_ctl.acc   = rvalid_reg;
                st_ctl.first = (rd_pos_x == '0);
                if (idx_reg < cnt_x)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg[AW-1:0];
                    idx_next  = idx_reg + IW'(1);
                end
                else if (!rvalid_reg)
                    state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase

        // entering the scan: restart index and accumulator
        if (state_next == S_SCAN && state_reg != S_SCAN)
        begin
            st_ctl.clear = 1'b1;
            idx_next     = '0;
        end
    end

    sota_stats #(
        .SUM_W (SUM_W)
    ) u_stats (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (st_ctl),
        .din        (rd_data_reg),
        .largest_q  (st_max),
        .smallest_q (st_min),
        .total_q    (st_sum)
    );

    assign out_valid   = out_valid_reg;
    assign status      = o_status_reg;
    assign data        = o_data_reg;
    assign found_at    = o_found_reg;
    assign entry_count = o_count_reg;
    assign largest     = o_max_reg;
    assign smallest    = o_min_reg;
    assign total       = o_total_reg;

endmodule

`default_nettype wire

[sv/sota_stats.sv]
// ----------------------------------------------------------------------------
// sota_stats
// Running max, min and sum over the entries streamed out of the table.
// ----------------------------------------------------------------------------
`default_nettype none

module sota_stats #(
    parameter int SUM_W = 36
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire sota_pkg::stat_ctl_t             ctl,
    input  wire logic signed [sota_pkg::DATA_W-1:0] din,
    output logic signed [sota_pkg::DATA_W-1:0]   largest_q,
    output logic signed [sota_pkg::DATA_W-1:0]   smallest_q,
    output logic signed [SUM_W-1:0]              total_q
);
    import sota_pkg::*;

    logic signed [DATA_W-1:0] max_reg, max_next;
    logic signed [DATA_W-1:0] min_reg, min_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [SUM_W-1:0]  din_x;

    assign din_x = SUM_W'(din);

    // accumulate one entry per cycle while acc is set
    always_comb
    begin
        max_next = max_reg;
        min_next = min_reg;
        sum_next = sum_reg;
        if (ctl.clear)
        begin
            max_next = '0;
            min_next = '0;
            sum_next = '0;
        end
        else if (ctl.acc)
        begin
            if (ctl.first)
            begin
                max_next = din;
                min_next = din;
                sum_next = din_x;
            end
            else
            begin
                if (din > max_reg)
                    max_next = din;
                if (din < min_reg)
                    min_next = din;
                sum_next = sum_reg + din_x;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= '0;
            min_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            max_reg <= max_next;
            min_reg <= min_next;
            sum_reg <= sum_next;
        end
    end

    assign largest_q  = max_reg;
    assign smallest_q = min_reg;
    assign total_q    = sum_reg;

endmodule

`default_nettype wire

[sv/sota_checker.sv]
// ----------------------------------------------------------------------------
// sota_checker
// Port-level checks on the array table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sota_checker #(
    parameter int CAPACITY = sota_pkg::CAPACITY_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire logic                                in_ready,
    input  wire logic                                out_valid,
    input  wire logic                                out_ready,
    input  wire logic [1:0]                          status,
    input  wire logic signed [sota_pkg::DATA_W-1:0]  data,
    input  wire logic [3:0]                          found_at,
    input  wire logic signed [sota_pkg::DATA_W-1:0]  largest,
    input  wire logic signed [sota_pkg::DATA_W-1:0]  smallest
);
    import sota_pkg::*;

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken while another is in progress");

    // failed items return no data
    a_fail_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> data == '0)
        else $error("data nonzero on failed item");

    // a miss reports position zero
    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_MISS |-> found_at == '0)
        else $error("found_at nonzero on miss");

    // max never below min
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> largest >= smallest)
        else $error("largest below smallest");

    // held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data))
        else $error("result dropped while stalled");

endmodule

bind self_organizing_array_table sota_checker #(.CAPACITY(CAPACITY)) u_sota_checker (.*);

`default_nettype wire
